@@ rtl/core/ofa_pkg.sv @@
// Shared widths and fixed filter constants for the oversampling moving-average filter.
package ofa_pkg;

  // Field widths
  localparam int SAMPLE_W = 10;
  localparam int OUT_W    = 12;
  localparam int FIXED_W  = 22;

  // Oversampled value is the group sum shifted down by this many bits
  localparam int OVS_SHIFT = 2;

  // Moving average: fraction bits and alpha = 1/DECAY_DENOMINATOR (power of two)
  localparam int FRACTION_BITS     = 10;
  localparam int DECAY_DENOMINATOR = 32;
  localparam int DECAY_SHIFT       = $clog2(DECAY_DENOMINATOR);

  // Width of the update sum before the divide by the decay denominator
  localparam int EMA_W = FIXED_W + DECAY_SHIFT + 2;

  // Saturation limits
  localparam logic [OUT_W-1:0]   OUT_MAX   = '1;
  localparam logic [FIXED_W-1:0] FIXED_MAX = '1;

  // Transfer bus widths, whole bytes
  localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * OUT_W + FIXED_W + 7) / 8) * 8;

endpackage

@@ rtl/core/ofa_accum.sv @@
// Group accumulator: sums samples and emits the decimated value at each group end.
module ofa_accum #(
  parameter int GROUP_SIZE = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          smp_valid,
  output logic                          smp_ready,
  input  logic [ofa_pkg::SAMPLE_W-1:0]  smp,
  output logic                          ovs_valid,
  input  logic                          ovs_ready,
  output logic [ofa_pkg::OUT_W-1:0]     ovs
);
  import ofa_pkg::*;

  localparam int ACC_W = $clog2(GROUP_SIZE * ((1 << SAMPLE_W) - 1) + 1);
  localparam int CNT_W = $clog2(GROUP_SIZE);

  logic [ACC_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OUT_W-1:0] ovs_r, ovs_nxt;
  logic             ovs_valid_r, ovs_valid_nxt;
  logic             acc;
  logic             last;
  logic [ACC_W-1:0] total;
  logic [ACC_W-1:0] quot;

  // Take a sample whenever the result register is free or being drained
  assign smp_ready = !ovs_valid_r || ovs_ready;
  assign acc       = smp_valid && smp_ready;
  assign last      = (cnt_r == CNT_W'(GROUP_SIZE - 1));

  // Add the sample and decimate with saturation
  always_comb begin
    total   = sum_r + ACC_W'(smp);
    quot    = total >> OVS_SHIFT;
    ovs_nxt = (quot > ACC_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(quot);
  end

  // Advance the count, clear at group end
  always_comb begin
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    ovs_valid_nxt = ovs_valid_r && !ovs_ready;
    if (acc) begin
      if (last) begin
        sum_nxt       = '0;
        cnt_nxt       = '0;
        ovs_valid_nxt = 1'b1;
      end else begin
        sum_nxt = total;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      ovs_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      ovs_valid_r <= ovs_valid_nxt;
    end
  end

  // Hold the decimated value until transferred
  always_ff @(posedge clk) begin
    if (acc && last) begin
      ovs_r <= ovs_nxt;
    end
  end

  assign ovs_valid = ovs_valid_r;
  assign ovs       = ovs_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(GROUP_SIZE - 1))
    else $error("group count beyond group size");

  a_group_clear: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && acc && last |=> cnt_r == '0 && sum_r == '0 && ovs_valid_r)
    else $error("group end did not clear accumulator");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && acc && !last |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("group count did not advance");

endmodule

@@ rtl/core/ofa_ema.sv @@
// Moving-average update stage with registered results.
module ofa_ema (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ovs_valid,
  output logic                          ovs_ready,
  input  logic [ofa_pkg::OUT_W-1:0]     ovs,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [ofa_pkg::OUT_W-1:0]     res_ovs,
  output logic [ofa_pkg::OUT_W-1:0]     res_filt,
  output logic [ofa_pkg::FIXED_W-1:0]   res_fixed
);
  import ofa_pkg::*;

  localparam logic [FIXED_W:0] HALF     = (FIXED_W + 1)'((1 << FRACTION_BITS) >> 1);
  localparam logic [EMA_W-1:0] ROUND_IN = EMA_W'(DECAY_DENOMINATOR / 2);

  logic [FIXED_W-1:0] avg_r, avg_nxt;
  logic [FIXED_W-1:0] fixed_r;
  logic [OUT_W-1:0]   ovs_r, filt_r, filt_nxt;
  logic               res_valid_r;
  logic               acc;
  logic [EMA_W-1:0]   upd;
  logic [EMA_W-1:0]   quot;
  logic [FIXED_W:0]   rnd;
  logic [FIXED_W:0]   fval;

  assign ovs_ready = !res_valid_r || res_ready;
  assign acc       = ovs_valid && ovs_ready;

  // avg' = (ovs << F + avg * (D-1) + D/2) / D, saturated
  always_comb begin
    upd = (EMA_W'(ovs) << FRACTION_BITS)
        + ((EMA_W'(avg_r) << DECAY_SHIFT) - EMA_W'(avg_r))
        + ROUND_IN;
    quot    = upd >> DECAY_SHIFT;
    avg_nxt = (quot > EMA_W'(FIXED_MAX)) ? FIXED_MAX : FIXED_W'(quot);
  end

  // Round half up to an integer and saturate
  always_comb begin
    rnd      = {1'b0, avg_nxt} + HALF;
    fval     = rnd >> FRACTION_BITS;
    filt_nxt = (fval > (FIXED_W + 1)'(OUT_MAX)) ? OUT_MAX : OUT_W'(fval);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        avg_r <= avg_nxt;
      end
      res_valid_r <= acc || (res_valid_r && !res_ready);
    end
  end

  // Hold the result until transferred
  always_ff @(posedge clk) begin
    if (acc) begin
      ovs_r   <= ovs;
      filt_r  <= filt_nxt;
      fixed_r <= avg_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res_ovs   = ovs_r;
  assign res_filt  = filt_r;
  assign res_fixed = fixed_r;

  a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> fixed_r == avg_r)
    else $error("result disagrees with average state");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && acc |=> res_valid_r)
    else $error("accepted value gave no result");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !acc |=> $stable(avg_r))
    else $error("average changed without a transfer");

endmodule

@@ rtl/core/oversample_ema_filter_top.sv @@
// Top level: 10-bit samples in, decimated and moving-average results out.
// A result is registered after the sample that completes a group, first in the
// accumulator result register, then in the average result register.
// Throughput: one sample per cycle unless out_tready holds the result path back;
// one result per GROUP_SIZE samples.
// Reset (rst_n low, synchronous) clears the group sum, count, average and valids.
module oversample_ema_filter_top #(
  parameter int GROUP_SIZE = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ofa_pkg::IN_DATA_W-1:0]     in_tdata,  // [9:0] sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [11:0] oversampled_value, [23:12] filtered_value, [45:24] filtered_fixed
  output logic [ofa_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import ofa_pkg::*;

  logic               ovs_valid;
  logic               ovs_ready;
  logic [OUT_W-1:0]   ovs;
  logic [OUT_W-1:0]   res_ovs;
  logic [OUT_W-1:0]   res_filt;
  logic [FIXED_W-1:0] res_fixed;

  // Accumulate and decimate
  ofa_accum #(
    .GROUP_SIZE (GROUP_SIZE)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (in_tvalid),
    .smp_ready (in_tready),
    .smp       (in_tdata[SAMPLE_W-1:0]),
    .ovs_valid (ovs_valid),
    .ovs_ready (ovs_ready),
    .ovs       (ovs)
  );

  // Update the moving average
  ofa_ema u_ema (
    .clk       (clk),
    .rst_n     (rst_n),
    .ovs_valid (ovs_valid),
    .ovs_ready (ovs_ready),
    .ovs       (ovs),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_ovs   (res_ovs),
    .res_filt  (res_filt),
    .res_fixed (res_fixed)
  );

  // Pack result fields from the lowest bit up, zero pad
  assign out_tdata = OUT_DATA_W'({res_fixed, res_filt, res_ovs});

endmodule
